// ----- hdl/lea128_ofb_cipher_top_assert.svh -----
// Assertion macros used by the cipher controller.
// Expects signals clk and arst_n in the scope of each use.
`ifndef LEA128_OFB_CIPHER_TOP_ASSERT_SVH
`define LEA128_OFB_CIPHER_TOP_ASSERT_SVH

// same-cycle implication
`define LEA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LEA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/lea128_pkg.sv -----
// Shared types, constants and functions for the LEA-128 OFB cipher.
// No dependencies.
package lea128_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CNT_W     = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_LOW  = 3'd0,
		CFG_KEY_HIGH = 3'd1,
		CFG_IV_LOW   = 3'd2,
		CFG_IV_HIGH  = 3'd3,
		CFG_MODE     = 3'd4
	} lea_cfg_idx_t;

	localparam logic MODE_OFB = 1'b0;
	localparam logic MODE_ECB = 1'b1;

	localparam logic [CNT_W-1:0] BLOCK_BYTES = 5'd16;

	localparam logic [31:0] LEA_DELTA [4] = '{
		32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec
	};

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} lea_cmd_t;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
		logic [63:0] w;
		w = {v, v} << s;
		return w[63:32];
	endfunction

endpackage

// ----- hdl/lea128_ctrl.sv -----
// Controller: sequences load, rounds and result hand-off.
// Depends on lea128_pkg and lea128_ofb_cipher_top_assert.svh.
`include "lea128_ofb_cipher_top_assert.svh"

module lea128_ctrl
	import lea128_pkg::*;
#(
	parameter int ROUNDS  = 24,
	parameter int ROUND_W = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output lea_cmd_t           cmd,
	output logic [ROUND_W-1:0] round
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} state_t;

	state_t             state_q, state_d;
	logic [ROUND_W-1:0] round_q;
	logic               out_valid_q;
	logic               out_free;
	logic               last_round;

	assign out_free   = !out_valid_q || out_ready;
	assign last_round = (round_q == ROUND_W'(ROUNDS - 1));

	assign cmd.finish = (state_q == ST_FIN) && out_free;
	assign in_ready   = (state_q == ST_IDLE) || cmd.finish;
	assign cmd.load   = in_valid && in_ready;
	assign cmd.step   = (state_q == ST_RUN);
	assign round      = round_q;
	assign out_valid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (last_round) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (cmd.load) state_d = ST_RUN;
				else if (cmd.finish) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			round_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) round_q <= '0;
			else if (cmd.step && !last_round) round_q <= round_q + 1'b1;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	`LEA_ASSERT_NEXT(a_accept_runs, cmd.load, state_q == ST_RUN, "accepted transaction did not start rounds")
	`LEA_ASSERT_NOW(a_round_bound, state_q == ST_RUN, round_q <= ROUND_W'(ROUNDS - 1), "round counter overran")
	`LEA_ASSERT_NEXT(a_finish_valid, cmd.finish, out_valid_q, "finished result not presented")
	`LEA_ASSERT_NEXT(a_fin_stall, state_q == ST_FIN && out_valid_q && !out_ready, state_q == ST_FIN, "result dropped while output stalled")

endmodule

// ----- hdl/lea128_dp.sv -----
// Datapath: configuration registers, shared LEA round unit with on-the-fly
// key schedule, OFB feedback and output register. Depends on lea128_pkg.
module lea128_dp
	import lea128_pkg::*;
#(
	parameter int ROUND_W = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lea_cmd_t             cmd,
	input  logic [ROUND_W-1:0]   round,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic [63:0]          block_low,
	input  logic [63:0]          block_high,
	input  logic [CNT_W-1:0]     byte_count,
	input  logic                 first_block,
	output logic [63:0]          result_low,
	output logic [63:0]          result_high,
	output logic [CNT_W-1:0]     valid_bytes
);

	logic [63:0]      key_low_q, key_high_q, iv_low_q, iv_high_q;
	logic             mode_q;
	logic [127:0]     fb_q;
	logic [31:0]      x_q [4];
	logic [31:0]      t_q [4];
	logic [127:0]     blk_q;
	logic [CNT_W-1:0] cnt_q;
	logic             item_mode_q;
	logic [63:0]      res_low_q, res_high_q;
	logic [CNT_W-1:0] res_cnt_q;

	logic [127:0]     fb_eff, x_src, x_flat, res_raw, mask;
	logic [CNT_W-1:0] cnt_sat;
	logic [4:0]       ridx;
	logic [31:0]      d;
	logic [31:0]      t_d [4];
	logic [31:0]      x_d [4];

	assign fb_eff  = (cmd.finish && item_mode_q == MODE_OFB) ? x_flat : fb_q;
	assign x_flat  = {x_q[3], x_q[2], x_q[1], x_q[0]};
	assign cnt_sat = (byte_count > BLOCK_BYTES) ? BLOCK_BYTES : byte_count;

	always_comb begin
		if (mode_q == MODE_ECB) x_src = {block_high, block_low};
		else if (first_block) x_src = {iv_high_q, iv_low_q};
		else x_src = fb_eff;
	end

	always_comb begin
		ridx   = 5'(round);
		d      = LEA_DELTA[ridx[1:0]];
		t_d[0] = rotl32(t_q[0] + rotl32(d, ridx), 5'd1);
		t_d[1] = rotl32(t_q[1] + rotl32(d, ridx + 5'd1), 5'd3);
		t_d[2] = rotl32(t_q[2] + rotl32(d, ridx + 5'd2), 5'd6);
		t_d[3] = rotl32(t_q[3] + rotl32(d, ridx + 5'd3), 5'd11);
		x_d[0] = rotl32((x_q[0] ^ t_d[0]) + (x_q[1] ^ t_d[1]), 5'd9);
		x_d[1] = rotl32((x_q[1] ^ t_d[2]) + (x_q[2] ^ t_d[1]), 5'd27);
		x_d[2] = rotl32((x_q[2] ^ t_d[3]) + (x_q[3] ^ t_d[1]), 5'd29);
		x_d[3] = x_q[0];
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			mask[8*i +: 8] = (cnt_q > CNT_W'(i)) ? 8'hff : 8'h00;
		end
		res_raw = (item_mode_q == MODE_ECB) ? x_flat : (x_flat ^ blk_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			iv_low_q   <= '0;
			iv_high_q  <= '0;
			mode_q     <= MODE_OFB;
			fb_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LOW:  key_low_q  <= cfg_data;
					CFG_KEY_HIGH: key_high_q <= cfg_data;
					CFG_IV_LOW:   iv_low_q   <= cfg_data;
					CFG_IV_HIGH:  iv_high_q  <= cfg_data;
					CFG_MODE:     mode_q     <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.finish && item_mode_q == MODE_OFB) fb_q <= x_flat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q[0]      <= x_src[31:0];
			x_q[1]      <= x_src[63:32];
			x_q[2]      <= x_src[95:64];
			x_q[3]      <= x_src[127:96];
			t_q[0]      <= key_low_q[31:0];
			t_q[1]      <= key_low_q[63:32];
			t_q[2]      <= key_high_q[31:0];
			t_q[3]      <= key_high_q[63:32];
			blk_q       <= {block_high, block_low};
			cnt_q       <= cnt_sat;
			item_mode_q <= mode_q;
		end else if (cmd.step) begin
			x_q <= x_d;
			t_q <= t_d;
		end
		if (cmd.finish) begin
			res_low_q  <= res_raw[63:0] & mask[63:0];
			res_high_q <= res_raw[127:64] & mask[127:64];
			res_cnt_q  <= cnt_q;
		end
	end

	assign result_low  = res_low_q;
	assign result_high = res_high_q;
	assign valid_bytes = res_cnt_q;

endmodule

// ----- hdl/lea128_ofb_cipher_top.sv -----
// LEA-128 cipher, single block or OFB stream. One block at a time through a
// single round unit, one round per cycle; a new block is taken only when the
// result of the last one is handed to the output register. Reset clears keys,
// IV, mode, OFB feedback and control.
// Depends on lea128_pkg, lea128_ctrl and lea128_dp.
module lea128_ofb_cipher_top
	import lea128_pkg::*;
#(
	parameter int ROUNDS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [63:0]          block_low,
	input  logic [63:0]          block_high,
	input  logic [CNT_W-1:0]     byte_count,
	input  logic                 first_block,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          result_low,
	output logic [63:0]          result_high,
	output logic [CNT_W-1:0]     valid_bytes
);

	localparam int ROUND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

	lea_cmd_t           cmd;
	logic [ROUND_W-1:0] round;

	assign cfg_ready = 1'b1;

	lea128_ctrl #(
		.ROUNDS  (ROUNDS),
		.ROUND_W (ROUND_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.round     (round)
	);

	lea128_dp #(
		.ROUND_W (ROUND_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.round       (round),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.block_low   (block_low),
		.block_high  (block_high),
		.byte_count  (byte_count),
		.first_block (first_block),
		.result_low  (result_low),
		.result_high (result_high),
		.valid_bytes (valid_bytes)
	);

endmodule

// ----- sim/lea128_ofb_cipher_top_tb.sv -----
// Self-checking testbench for lea128_ofb_cipher_top: LEA-128 single block and OFB stream.
// Holds its own cipher model in a small scoreboard class; needs lea128_pkg and the RTL.
module lea128_ofb_cipher_top_tb;
	import lea128_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROUNDS         = 24;
	localparam int CFG_SLOTS      = 1 << CFG_IDX_W;
	localparam int RAND_PHASES    = 8;
	localparam int PHASE_ITEMS    = 200;
	localparam int HOLD_AT_RESULT = 300;
	localparam int HOLD_CYCLES    = 500;
	localparam int DRAIN_LIMIT    = 20000;
	localparam logic [63:0] ONES  = '1;

	typedef struct packed {
		logic [63:0]      lo;
		logic [63:0]      hi;
		logic [CNT_W-1:0] cnt;
	} lea_result_t;

	class lea_cipher_tracker;
		logic [63:0]  key_lo, key_hi, iv_lo, iv_hi;
		logic         mode;
		logic [127:0] feedback;
		lea_result_t  pending_ciphertexts[$];
		int           mismatches;

		function new();
			key_lo = '0;
			key_hi = '0;
			iv_lo = '0;
			iv_hi = '0;
			mode = MODE_OFB;
			feedback = '0;
			mismatches = 0;
		endfunction

		function logic [31:0] rol(logic [31:0] v, int unsigned s);
			s = s % 32;
			if (s == 0)
				return v;
			return (v << s) | (v >> (32 - s));
		endfunction

		function logic [31:0] ror(logic [31:0] v, int unsigned s);
			return rol(v, (32 - (s % 32)) % 32);
		endfunction

		function logic [31:0] delta(int unsigned r);
			case (r % 4)
				0: return 32'hc3efe9db;
				1: return 32'h44626b02;
				2: return 32'h79e27c8a;
				default: return 32'h78df30ec;
			endcase
		endfunction

		function logic [127:0] encrypt(logic [127:0] blk);
			logic [31:0] t[4];
			logic [31:0] x[4];
			logic [31:0] d, n0, n1, n2;
			t[0] = key_lo[31:0];
			t[1] = key_lo[63:32];
			t[2] = key_hi[31:0];
			t[3] = key_hi[63:32];
			for (int i = 0; i < 4; i++)
				x[i] = blk[32*i +: 32];
			for (int unsigned r = 0; r < ROUNDS; r++) begin
				d = delta(r);
				t[0] = rol(t[0] + rol(d, r), 1);
				t[1] = rol(t[1] + rol(d, r + 1), 3);
				t[2] = rol(t[2] + rol(d, r + 2), 6);
				t[3] = rol(t[3] + rol(d, r + 3), 11);
				n0 = rol((x[0] ^ t[0]) + (x[1] ^ t[1]), 9);
				n1 = ror((x[1] ^ t[2]) + (x[2] ^ t[1]), 5);
				n2 = ror((x[2] ^ t[3]) + (x[3] ^ t[1]), 3);
				x[3] = x[0];
				x[0] = n0;
				x[1] = n1;
				x[2] = n2;
			end
			return {x[3], x[2], x[1], x[0]};
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
			case (idx)
				CFG_KEY_LOW:  key_lo = data;
				CFG_KEY_HIGH: key_hi = data;
				CFG_IV_LOW:   iv_lo = data;
				CFG_IV_HIGH:  iv_hi = data;
				CFG_MODE:     mode = data[0];
				default: ;
			endcase
		endfunction

		function void note_block(logic [63:0] lo, logic [63:0] hi, logic [CNT_W-1:0] cnt,
				logic first);
			int unsigned n;
			logic [127:0] res, keep;
			lea_result_t e;
			n = (cnt > BLOCK_BYTES) ? BLOCK_BYTES : cnt;
			if (mode == MODE_ECB) begin
				res = encrypt({hi, lo});
			end else begin
				if (first)
					feedback = {iv_hi, iv_lo};
				feedback = encrypt(feedback);
				res = {hi, lo} ^ feedback;
			end
			keep = '0;
			for (int unsigned i = 0; i < n; i++)
				keep[8*i +: 8] = 8'hff;
			res &= keep;
			e.lo = res[63:0];
			e.hi = res[127:64];
			e.cnt = n[CNT_W-1:0];
			pending_ciphertexts.push_back(e);
		endfunction

		function void check_result(logic [63:0] lo, logic [63:0] hi, logic [CNT_W-1:0] cnt);
			lea_result_t e;
			if (pending_ciphertexts.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %h %h %0d",
					$time, hi, lo, cnt);
				return;
			end
			e = pending_ciphertexts.pop_front();
			if (lo !== e.lo) begin
				mismatches++;
				$display("%0t: result_low expected %h actual %h", $time, e.lo, lo);
			end
			if (hi !== e.hi) begin
				mismatches++;
				$display("%0t: result_high expected %h actual %h", $time, e.hi, hi);
			end
			if (cnt !== e.cnt) begin
				mismatches++;
				$display("%0t: valid_bytes expected %0d actual %0d", $time, e.cnt, cnt);
			end
		endfunction

		function void flag_leftovers();
			lea_result_t e;
			if (pending_ciphertexts.size() != 0) begin
				e = pending_ciphertexts[0];
				mismatches += pending_ciphertexts.size();
				$display("%0t: %0d results missing, oldest expected %h %h %0d actual none",
					$time, pending_ciphertexts.size(), e.hi, e.lo, e.cnt);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [63:0]          block_low;
	logic [63:0]          block_high;
	logic [CNT_W-1:0]     byte_count;
	logic                 first_block;
	logic                 out_valid;
	logic                 out_ready;
	logic [63:0]          result_low;
	logic [63:0]          result_high;
	logic [CNT_W-1:0]     valid_bytes;

	int src_gap_max = 15;
	int sink_gap_max = 15;

	lea_cipher_tracker book = new();

	lea128_ofb_cipher_top #(
		.ROUNDS(ROUNDS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.block_low(block_low),
		.block_high(block_high),
		.byte_count(byte_count),
		.first_block(first_block),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_low(result_low),
		.result_high(result_high),
		.valid_bytes(valid_bytes)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] pick_extreme_or_rand();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return ONES;
			default: return rand64();
		endcase
	endfunction

	task automatic send_block(input logic [63:0] lo, input logic [63:0] hi,
			input logic [CNT_W-1:0] cnt, input logic first);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		block_low <= lo;
		block_high <= hi;
		byte_count <= cnt;
		first_block <= first;
		do @(posedge clk); while (!in_ready);
		book.note_block(lo, hi, cnt, first);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.pending_ciphertexts.size() != 0)
			@(posedge clk);
	endtask

	task automatic apply_settings(input logic [63:0] k_lo, input logic [63:0] k_hi,
			input logic [63:0] v_lo, input logic [63:0] v_hi, input logic mode,
			input bit spare);
		logic [63:0] data;
		int last;
		last = spare ? CFG_SLOTS - 1 : CFG_MODE;
		for (int i = 0; i <= last; i++) begin
			case (i)
				CFG_KEY_LOW:  data = k_lo;
				CFG_KEY_HIGH: data = k_hi;
				CFG_IV_LOW:   data = v_lo;
				CFG_IV_HIGH:  data = v_hi;
				CFG_MODE:     data = {$urandom, $urandom_range(0, 1) == 0 ? 31'd0 : 31'h7fffffff,
					mode};
				default:      data = rand64();
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= i[CFG_IDX_W-1:0];
			cfg_data <= data;
			do @(posedge clk); while (!cfg_ready);
			book.write_reg(i[CFG_IDX_W-1:0], data);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input int n_items, input bit pause_midway);
		int sent, msg_len;
		bit paused;
		logic [CNT_W-1:0] cnt;
		sent = 0;
		paused = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 9) == 0) begin
				send_block(rand64(), rand64(), CNT_W'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)));
				sent++;
			end else begin
				msg_len = $urandom_range(1, 12);
				for (int k = 0; k < msg_len && sent < n_items; k++) begin
					cnt = (k == msg_len - 1) ? CNT_W'($urandom_range(1, 16)) : BLOCK_BYTES;
					send_block(rand64(), rand64(), cnt, k == 0);
					sent++;
				end
			end
			if (pause_midway && !paused && sent >= n_items / 2) begin
				paused = 1;
				wait_results_done();
			end
		end
	endtask

	initial begin
		int results_seen;
		int gap;
		results_seen = 0;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (results_seen == HOLD_AT_RESULT)
				gap = HOLD_CYCLES;
			else
				gap = $urandom_range(0, sink_gap_max);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			book.check_result(result_low, result_high, valid_bytes);
			results_seen++;
		end
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int guard;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		block_low <= '0;
		block_high <= '0;
		byte_count <= '0;
		first_block <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// OFB from the zero feedback left by reset, no first block yet
		send_block(64'h0123456789abcdef, 64'hfedcba9876543210, BLOCK_BYTES, 1'b0);
		send_block(ONES, ONES, 5'd0, 1'b0);
		send_block(rand64(), rand64(), BLOCK_BYTES, 1'b0);
		wait_results_done();

		apply_settings(ONES, ONES, '0, ONES, MODE_ECB, 1'b1);
		send_block('0, '0, BLOCK_BYTES, 1'b1);
		send_block(ONES, ONES, BLOCK_BYTES, 1'b0);
		send_block(rand64(), rand64(), 5'd1, 1'b0);
		send_block(rand64(), rand64(), 5'd7, 1'b1);
		send_block(rand64(), rand64(), 5'd8, 1'b0);
		send_block(rand64(), rand64(), 5'd9, 1'b0);
		send_block(rand64(), rand64(), 5'd15, 1'b1);
		send_block(rand64(), rand64(), 5'd17, 1'b0);
		send_block(ONES, ONES, 5'd31, 1'b0);
		send_block(ONES, ONES, 5'd0, 1'b1);
		wait_results_done();

		// chain resumes where the first OFB run left it
		apply_settings(rand64(), rand64(), ONES, '0, MODE_OFB, 1'b0);
		send_block(rand64(), rand64(), BLOCK_BYTES, 1'b0);
		send_block(rand64(), rand64(), BLOCK_BYTES, 1'b1);
		send_block(ONES, '0, BLOCK_BYTES, 1'b0);
		send_block(rand64(), rand64(), 5'd5, 1'b0);
		send_block(rand64(), rand64(), 5'd12, 1'b1);
		send_block(rand64(), rand64(), 5'd0, 1'b0);
		send_block(rand64(), rand64(), 5'd31, 1'b0);
		wait_results_done();

		for (int p = 0; p < RAND_PHASES; p++) begin
			src_gap_max = (p % 4 == 1 || p % 4 == 3) ? 0 : 15;
			sink_gap_max = (p % 4 == 2 || p % 4 == 3) ? 0 : 15;
			apply_settings(pick_extreme_or_rand(), pick_extreme_or_rand(),
				pick_extreme_or_rand(), pick_extreme_or_rand(),
				(p % 3 == 2) ? MODE_ECB : MODE_OFB, p == RAND_PHASES - 1);
			run_phase(PHASE_ITEMS, p == 4);
			wait_results_done();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		guard = 0;
		while (book.pending_ciphertexts.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (ROUNDS + 8) @(posedge clk);
		book.flag_leftovers();
		if (book.mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
